// ===== hdl/biou_pkg.sv =====
package biou_pkg;

    // default field widths
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // register stages in the front end before the divider chain
    localparam int FRONT_STAGES = 3;

endpackage

// ===== hdl/box_intersection_over_union.sv =====
// Intersection over union of two axis-aligned boxes.
// Input channel (s_valid/s_ready): one box pair per item, each box given
// as center x, center y, width and height, COORD_BITS unsigned each.
// Result channel (m_valid/m_ready): m_overlap_ratio, unsigned with
// FRAC_BITS fraction bits (1 << FRAC_BITS is 1.0), rounded down, and
// m_union_empty, set when both boxes have zero area (ratio then 0).
// Pipeline: three front stages for edges, the three area products and
// the union, then one divider cell per quotient bit, FRAC_BITS + 1
// cells in a row.
// Throughput: one item per cycle; every stage holds its own valid bit.
// A stall at m_ready backs up stage by stage; empty stages keep filling,
// so s_ready stays high until the whole chain is full.
// Reset (aresetn low, synchronous) clears all valid bits; items in
// flight are dropped.
module box_intersection_over_union #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = biou_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_box_a_center_x,
    input  logic [COORD_BITS-1:0] s_box_a_center_y,
    input  logic [COORD_BITS-1:0] s_box_a_width,
    input  logic [COORD_BITS-1:0] s_box_a_height,
    input  logic [COORD_BITS-1:0] s_box_b_center_x,
    input  logic [COORD_BITS-1:0] s_box_b_center_y,
    input  logic [COORD_BITS-1:0] s_box_b_width,
    input  logic [COORD_BITS-1:0] s_box_b_height,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FRAC_BITS:0]    m_overlap_ratio,
    output logic                  m_union_empty
);
    import biou_pkg::*;

    localparam int DW = 2 * COORD_BITS + 1;
    localparam int QW = FRAC_BITS + 1;

    // links between cells, entry 0 is the front end output
    logic          lnk_valid [QW+1];
    logic          lnk_ready [QW+1];
    logic [DW-1:0] lnk_rem   [QW+1];
    logic [DW-1:0] lnk_div   [QW+1];
    logic [QW-1:0] lnk_quo   [QW+1];
    logic          lnk_empty [QW+1];

    // edges, intersection, areas and union
    biou_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .a_cx      (s_box_a_center_x),
        .a_cy      (s_box_a_center_y),
        .a_w       (s_box_a_width),
        .a_h       (s_box_a_height),
        .b_cx      (s_box_b_center_x),
        .b_cy      (s_box_b_center_y),
        .b_w       (s_box_b_width),
        .b_h       (s_box_b_height),
        .out_valid (lnk_valid[0]),
        .out_ready (lnk_ready[0]),
        .out_inter (lnk_rem[0]),
        .out_union (lnk_div[0]),
        .out_empty (lnk_empty[0])
    );

    assign lnk_quo[0] = '0;

    // divider chain, most significant quotient bit first
    for (genvar k = 0; k < QW; k++) begin : g_cell
        biou_div_cell #(
            .DW      (DW),
            .QW      (QW),
            .BIT_POS (FRAC_BITS - k),
            .FIRST   (k == 0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lnk_valid[k]),
            .in_ready  (lnk_ready[k]),
            .rem_in    (lnk_rem[k]),
            .div_in    (lnk_div[k]),
            .quo_in    (lnk_quo[k]),
            .empty_in  (lnk_empty[k]),
            .out_valid (lnk_valid[k+1]),
            .out_ready (lnk_ready[k+1]),
            .rem_out   (lnk_rem[k+1]),
            .div_out   (lnk_div[k+1]),
            .quo_out   (lnk_quo[k+1]),
            .empty_out (lnk_empty[k+1])
        );
    end

    // last cell register is the output register
    assign lnk_ready[QW]   = m_ready;
    assign m_valid         = lnk_valid[QW];
    assign m_overlap_ratio = lnk_quo[QW];
    assign m_union_empty   = lnk_empty[QW];

endmodule

// ===== hdl/biou_front.sv =====
module biou_front #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [COORD_BITS-1:0]     a_cx,
    input  logic [COORD_BITS-1:0]     a_cy,
    input  logic [COORD_BITS-1:0]     a_w,
    input  logic [COORD_BITS-1:0]     a_h,
    input  logic [COORD_BITS-1:0]     b_cx,
    input  logic [COORD_BITS-1:0]     b_cy,
    input  logic [COORD_BITS-1:0]     b_w,
    input  logic [COORD_BITS-1:0]     b_h,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2*COORD_BITS:0]     out_inter,
    output logic [2*COORD_BITS:0]     out_union,
    output logic                      out_empty
);
    import biou_pkg::*;

    localparam int EW = COORD_BITS + 2;      // signed edge width
    localparam int AW = 2 * COORD_BITS;      // area width
    localparam int DW = AW + 1;              // union width

    logic signed [EW-1:0] a_left, a_right, a_top, a_bot;
    logic signed [EW-1:0] b_left, b_right, b_top, b_bot;
    logic signed [EW-1:0] min_r, max_l, min_t, max_b;
    logic signed [EW:0]   iw_full, ih_full;
    logic [COORD_BITS-1:0] iw, ih;

    logic s0_valid_reg, s1_valid_reg, s2_valid_reg;
    logic s0_ready, s1_ready, s2_ready;

    logic [COORD_BITS-1:0] iw_reg, ih_reg, aw_reg, ah_reg, bw_reg, bh_reg;
    logic [AW-1:0]         inter1_reg, area_a_reg, area_b_reg;
    logic [DW-1:0]         inter2_reg, union_reg;
    logic [DW-1:0]         union_next;
    logic                  empty_reg;

    // box edges, signed so corners below zero do not wrap
    always_comb begin
        a_left  = EW'(a_cx) - EW'(a_w >> 1);
        a_right = a_left + EW'(a_w);
        a_top   = EW'(a_cy) + EW'(a_h >> 1);
        a_bot   = a_top - EW'(a_h);
        b_left  = EW'(b_cx) - EW'(b_w >> 1);
        b_right = b_left + EW'(b_w);
        b_top   = EW'(b_cy) + EW'(b_h >> 1);
        b_bot   = b_top - EW'(b_h);
    end

    // intersection sides, clamped at zero
    always_comb begin
        min_r   = (a_right < b_right) ? a_right : b_right;
        max_l   = (a_left > b_left) ? a_left : b_left;
        min_t   = (a_top < b_top) ? a_top : b_top;
        max_b   = (a_bot > b_bot) ? a_bot : b_bot;
        iw_full = (EW+1)'(min_r) - (EW+1)'(max_l);
        ih_full = (EW+1)'(min_t) - (EW+1)'(max_b);
        iw      = iw_full[EW] ? '0 : iw_full[COORD_BITS-1:0];
        ih      = ih_full[EW] ? '0 : ih_full[COORD_BITS-1:0];
    end

    // per-stage flow control, bubbles collapse
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign in_ready = s0_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s0_ready) s0_valid_reg <= in_valid;
            if (s1_ready) s1_valid_reg <= s0_valid_reg;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage 0: sides and sizes
    always_ff @(posedge aclk) begin
        if (in_valid && s0_ready) begin
            iw_reg <= iw;
            ih_reg <= ih;
            aw_reg <= a_w;
            ah_reg <= a_h;
            bw_reg <= b_w;
            bh_reg <= b_h;
        end
    end

    // stage 1: areas
    always_ff @(posedge aclk) begin
        if (s0_valid_reg && s1_ready) begin
            inter1_reg <= iw_reg * ih_reg;
            area_a_reg <= aw_reg * ah_reg;
            area_b_reg <= bw_reg * bh_reg;
        end
    end

    // stage 2: union
    assign union_next = DW'(area_a_reg) + DW'(area_b_reg) - DW'(inter1_reg);

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s2_ready) begin
            inter2_reg <= DW'(inter1_reg);
            union_reg  <= union_next;
            empty_reg  <= (union_next == '0);
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_inter = inter2_reg;
    assign out_union = union_reg;
    assign out_empty = empty_reg;

endmodule

// ===== hdl/biou_div_cell.sv =====
module biou_div_cell #(
    parameter int DW      = 2 * biou_pkg::COORD_BITS_DEF + 1,
    parameter int QW      = biou_pkg::FRAC_BITS_DEF + 1,
    parameter int BIT_POS = 0,
    parameter bit FIRST   = 1'b0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] rem_in,
    input  logic [DW-1:0] div_in,
    input  logic [QW-1:0] quo_in,
    input  logic          empty_in,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] rem_out,
    output logic [DW-1:0] div_out,
    output logic [QW-1:0] quo_out,
    output logic          empty_out
);
    import biou_pkg::*;

    logic          valid_reg;
    logic [DW-1:0] rem_reg, div_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic          empty_reg;
    logic [DW:0]   trial;
    logic          ge;

    // one restoring step: shift (skipped in the first cell), compare, subtract
    always_comb begin
        trial    = FIRST ? {1'b0, rem_in} : {rem_in, 1'b0};
        ge       = (trial >= {1'b0, div_in});
        rem_next = ge ? DW'(trial - {1'b0, div_in}) : DW'(trial);
        quo_next = quo_in;
        quo_next[BIT_POS] = ge && !empty_in;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rem_reg   <= rem_next;
            div_reg   <= div_in;
            quo_reg   <= quo_next;
            empty_reg <= empty_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign div_out   = div_reg;
    assign quo_out   = quo_reg;
    assign empty_out = empty_reg;

endmodule

// ===== hdl/biou_checker.sv =====
module biou_checker #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = biou_pkg::FRAC_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [COORD_BITS-1:0] s_box_a_center_x,
    input logic [COORD_BITS-1:0] s_box_a_center_y,
    input logic [COORD_BITS-1:0] s_box_a_width,
    input logic [COORD_BITS-1:0] s_box_a_height,
    input logic [COORD_BITS-1:0] s_box_b_center_x,
    input logic [COORD_BITS-1:0] s_box_b_center_y,
    input logic [COORD_BITS-1:0] s_box_b_width,
    input logic [COORD_BITS-1:0] s_box_b_height,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [FRAC_BITS:0]    m_overlap_ratio,
    input logic                  m_union_empty
);
    import biou_pkg::*;

    localparam logic [FRAC_BITS:0] RATIO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // empty union always reports a zero ratio
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_union_empty |-> m_overlap_ratio == '0)
        else $error("empty union with nonzero ratio");

    // the ratio never exceeds one
    a_ratio_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_overlap_ratio <= RATIO_ONE)
        else $error("ratio above one");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_overlap_ratio)
            && $stable(m_union_empty))
        else $error("stalled result changed");

    // no result right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind box_intersection_over_union biou_checker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_biou_checker (.*);
